// ----- hdl/spr_pkg.sv -----
package spr_pkg;

  localparam int NODE_W    = 4;
  localparam int COST_IN_W = 16;
  localparam int DIST_W    = 20;
  localparam int RES_CNT_W = 4;

  localparam logic [DIST_W-1:0]    DIST_INF = 20'hFFFFF;
  localparam logic [DIST_W-1:0]    DIST_SAT = 20'hFFFFE;
  localparam logic [RES_CNT_W-1:0] LAST_RES = 4'd15;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_RECOMP = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] cost;
    logic              reach;
    logic              last;
  } spr_res_t;

endpackage

// ----- hdl/spr_ram.sv -----
module spr_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/spr_out_reg.sv -----
module spr_out_reg import spr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  input  spr_res_t res_i,
  output logic     res_free_o,
  output logic     out_valid_o,
  output spr_res_t out_res_o,
  input  logic     out_stall_i
);

  logic     valid_q;
  spr_res_t res_q;

  assign res_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hdl/spr_ctrl.sv -----
module spr_ctrl import spr_pkg::*; #(
  parameter int NODES = 16,
  parameter int COST_BITS = 16,
  localparam int IW = $clog2(NODES),
  localparam int AW = 2 * IW,
  localparam int LW = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W,
  localparam int RW = DIST_W + IW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [NODE_W-1:0]    node_a_i,
  input  logic [NODE_W-1:0]    node_b_i,
  input  logic [COST_IN_W-1:0] link_cost_i,
  output logic                 link_we_o,
  output logic [AW-1:0]        link_waddr_o,
  output logic [LW-1:0]        link_wdata_o,
  output logic [AW-1:0]        link_raddr_o,
  input  logic [LW-1:0]        link_rdata_i,
  output logic                 route_we_o,
  output logic [AW-1:0]        route_waddr_o,
  output logic [RW-1:0]        route_wdata_o,
  output logic [AW-1:0]        route_raddr_o,
  input  logic [RW-1:0]        route_rdata_i,
  output logic                 res_valid_o,
  output spr_res_t             res_o,
  input  logic                 res_free_i
);

  localparam logic [IW-1:0]        IDX_LAST = IW'(NODES - 1);
  localparam logic [IW-1:0]        RND_LAST = IW'(NODES - 2);
  localparam logic [6:0]           NODES_7  = 7'(NODES);
  localparam logic [COST_IN_W-1:0] COST_MAX = COST_IN_W'((64'd1 << LW) - 64'd1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LWR_AB,
    ST_LWR_BA,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_RLX,
    ST_RLX_WB,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_EMIT,
    ST_Q_HOP,
    ST_Q_ACC,
    ST_Q_UNR
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [NODE_W-1:0]      a_q, a_d, b_q, b_d;
  logic [LW-1:0]          cost_q, cost_d;
  logic                   wr_ok_q, wr_ok_d;
  logic [IW-1:0]          i_q, i_d, j_q, j_d, k_q, k_d, rnd_q, rnd_d;
  logic [IW-1:0]          kd_q, kd_d;
  logic                   dv_q, dv_d;
  logic [DIST_W-1:0]      best_q, best_d;
  logic [IW-1:0]          hop_q, hop_d;
  logic [IW-1:0]          cur_q, cur_d, nh_q, nh_d;
  logic [DIST_W-1:0]      acc_q, acc_d;
  logic [RES_CNT_W-1:0]   n_q, n_d;

  logic [IW-1:0]          ai, bi, clr_i, clr_j, hop_rd;
  logic [DIST_W-1:0]      dist_rd;
  logic [DIST_W:0]        cand_sum, acc_sum;
  logic [DIST_W-1:0]      cand_s, best_n;
  logic [IW-1:0]          hop_n;
  logic                   cand_take, pair_last, fin;
  logic                   a_ok, b_ok;
  logic [COST_IN_W-1:0]   cost_sat;

  assign ai      = IW'(a_q);
  assign bi      = IW'(b_q);
  assign clr_i   = clr_q[AW-1:IW];
  assign clr_j   = clr_q[IW-1:0];
  assign dist_rd = route_rdata_i[RW-1 -: DIST_W];
  assign hop_rd  = route_rdata_i[IW-1:0];

  // relaxation: one neighbour k per cycle, min kept in best_q/hop_q
  assign cand_sum  = (DIST_W+1)'(link_rdata_i) + (DIST_W+1)'(dist_rd);
  assign cand_s    = (cand_sum > (DIST_W+1)'(DIST_SAT)) ? DIST_SAT : cand_sum[DIST_W-1:0];
  assign cand_take = dv_q && (kd_q != i_q) && (link_rdata_i != '0) &&
                     (dist_rd != DIST_INF) && (cand_s < best_q);
  assign best_n    = cand_take ? cand_s : best_q;
  assign hop_n     = cand_take ? kd_q : hop_q;

  assign acc_sum   = (DIST_W+1)'(acc_q) + (DIST_W+1)'(link_rdata_i);
  assign pair_last = (i_q == IDX_LAST) && (j_q == IDX_LAST);
  assign fin       = (cur_q == bi) || (n_q == LAST_RES);
  assign a_ok      = {3'b000, node_a_i} < NODES_7;
  assign b_ok      = {3'b000, node_b_i} < NODES_7;
  assign cost_sat  = (link_cost_i > COST_MAX) ? COST_MAX : link_cost_i;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    a_d     = a_q;
    b_d     = b_q;
    cost_d  = cost_q;
    wr_ok_d = wr_ok_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    rnd_d   = rnd_q;
    kd_d    = kd_q;
    dv_d    = 1'b0;
    best_d  = best_q;
    hop_d   = hop_q;
    cur_d   = cur_q;
    nh_d    = nh_q;
    acc_d   = acc_q;
    n_d     = n_q;

    in_stall_o    = 1'b1;
    link_we_o     = 1'b0;
    link_waddr_o  = '0;
    link_wdata_o  = '0;
    link_raddr_o  = '0;
    route_we_o    = 1'b0;
    route_waddr_o = '0;
    route_wdata_o = '0;
    route_raddr_o = '0;
    res_valid_o   = 1'b0;
    res_o         = '0;

    case (state_q)
      ST_CLEAR: begin
        link_we_o     = 1'b1;
        link_waddr_o  = clr_q;
        route_we_o    = 1'b1;
        route_waddr_o = clr_q;
        route_wdata_o = (clr_i == clr_j) ? {DIST_W'(0), clr_i} : {DIST_INF, IW'(0)};
        clr_d         = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          a_d    = node_a_i;
          b_d    = node_b_i;
          cost_d = LW'(cost_sat);
          case (func_e'(func_i))
            FUNC_WRITE: begin
              wr_ok_d = a_ok && b_ok && (node_a_i != node_b_i);
              state_d = ST_LWR_AB;
            end
            FUNC_RECOMP: begin
              i_d     = '0;
              j_d     = '0;
              state_d = ST_INIT_RD;
            end
            FUNC_QUERY: begin
              state_d = (a_ok && b_ok) ? ST_Q_RD : ST_Q_UNR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_LWR_AB: begin
        link_we_o    = wr_ok_q;
        link_waddr_o = {ai, bi};
        link_wdata_o = cost_q;
        state_d      = ST_LWR_BA;
      end

      ST_LWR_BA: begin
        link_we_o    = wr_ok_q;
        link_waddr_o = {bi, ai};
        link_wdata_o = cost_q;
        state_d      = ST_IDLE;
      end

      ST_INIT_RD: begin
        link_raddr_o = {i_q, j_q};
        state_d      = ST_INIT_WR;
      end

      ST_INIT_WR: begin
        route_we_o    = 1'b1;
        route_waddr_o = {i_q, j_q};
        if (i_q == j_q) begin
          route_wdata_o = {DIST_W'(0), i_q};
        end else if (link_rdata_i != '0) begin
          route_wdata_o = {DIST_W'(link_rdata_i), j_q};
        end else begin
          route_wdata_o = {DIST_INF, IW'(0)};
        end
        state_d = ST_INIT_RD;
        if (j_q == IDX_LAST) begin
          j_d = '0;
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        if (pair_last) begin
          i_d     = '0;
          k_d     = '0;
          rnd_d   = '0;
          best_d  = DIST_INF;
          hop_d   = '0;
          state_d = ST_RLX;
        end
      end

      ST_RLX: begin
        link_raddr_o  = {i_q, k_q};
        route_raddr_o = {k_q, j_q};
        kd_d          = k_q;
        dv_d          = 1'b1;
        best_d        = best_n;
        hop_d         = hop_n;
        if (k_q == IDX_LAST) begin
          k_d     = '0;
          state_d = ST_RLX_WB;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_RLX_WB: begin
        // diagonal stays at zero distance, itself as next hop
        route_we_o    = (i_q != j_q);
        route_waddr_o = {i_q, j_q};
        route_wdata_o = {best_n, hop_n};
        best_d        = DIST_INF;
        hop_d         = '0;
        state_d       = ST_RLX;
        if (j_q == IDX_LAST) begin
          j_d = '0;
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        if (pair_last) begin
          i_d = '0;
          if (rnd_q == RND_LAST) begin
            state_d = ST_IDLE;
          end else begin
            rnd_d = rnd_q + 1'b1;
          end
        end
      end

      ST_Q_RD: begin
        route_raddr_o = {ai, bi};
        cur_d         = ai;
        acc_d         = '0;
        n_d           = '0;
        state_d       = ST_Q_CHK;
      end

      ST_Q_CHK: begin
        state_d = (dist_rd == DIST_INF) ? ST_Q_UNR : ST_Q_EMIT;
      end

      ST_Q_EMIT: begin
        res_valid_o   = 1'b1;
        res_o.node    = NODE_W'(cur_q);
        res_o.cost    = acc_q;
        res_o.reach   = 1'b1;
        res_o.last    = fin;
        route_raddr_o = {cur_q, bi};
        if (res_free_i) begin
          state_d = fin ? ST_IDLE : ST_Q_HOP;
        end
      end

      ST_Q_HOP: begin
        link_raddr_o = {cur_q, hop_rd};
        nh_d         = hop_rd;
        state_d      = ST_Q_ACC;
      end

      ST_Q_ACC: begin
        acc_d   = (acc_sum > (DIST_W+1)'(DIST_INF)) ? DIST_INF : acc_sum[DIST_W-1:0];
        cur_d   = nh_q;
        n_d     = n_q + 1'b1;
        state_d = ST_Q_EMIT;
      end

      ST_Q_UNR: begin
        res_valid_o = 1'b1;
        res_o.node  = b_q;
        res_o.cost  = '0;
        res_o.reach = 1'b0;
        res_o.last  = 1'b1;
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      dv_q    <= 1'b0;
      wr_ok_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rnd_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dv_q    <= dv_d;
      wr_ok_q <= wr_ok_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rnd_q   <= rnd_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    cost_q <= cost_d;
    kd_q   <= kd_d;
    best_q <= best_d;
    hop_q  <= hop_d;
    cur_q  <= cur_d;
    nh_q   <= nh_d;
    acc_q  <= acc_d;
  end

endmodule

// ----- hdl/shortest_path_routing_table_top.sv -----
// channel | handshake                | payload
// in      | in_valid_i / in_stall_o  | func_i, node_a_i, node_b_i, link_cost_i
// out     | out_valid_o / out_stall_i| path_node_o, path_cost_o, reachable_o, last_o
//
// after reset a clearing pass writes every entry of both memories, 2**(2*ceil(log2 NODES))
// entries (256 at 16 nodes), with in_stall_o high
// link write: a->b, then b->a; query: route read and reachability check, then per hop an emit,
// a next-hop read and a cost add; recompute: init pass, then N-1 rounds, one neighbour per cycle
// one item at a time; a result waits in the output register, the sequencer only
// holds on out_stall_i when it has another result to hand over
module shortest_path_routing_table_top import spr_pkg::*; #(
  parameter int NODES = 16,
  parameter int COST_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [NODE_W-1:0]    node_a_i,
  input  logic [NODE_W-1:0]    node_b_i,
  input  logic [COST_IN_W-1:0] link_cost_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [NODE_W-1:0]    path_node_o,
  output logic [DIST_W-1:0]    path_cost_o,
  output logic                 reachable_o,
  output logic                 last_o
);

  localparam int IW = $clog2(NODES);
  localparam int AW = 2 * IW;
  localparam int LW = (COST_BITS < COST_IN_W) ? COST_BITS : COST_IN_W;
  localparam int RW = DIST_W + IW;

  logic          link_we, route_we;
  logic [AW-1:0] link_waddr, link_raddr, route_waddr, route_raddr;
  logic [LW-1:0] link_wdata, link_rdata;
  logic [RW-1:0] route_wdata, route_rdata;
  logic          res_valid, res_free;
  spr_res_t      res, out_res;

  spr_ram #(.DATA_W(LW), .ADDR_W(AW)) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  spr_ram #(.DATA_W(RW), .ADDR_W(AW)) u_route_mem (
    .clk_i   (clk_i),
    .we_i    (route_we),
    .waddr_i (route_waddr),
    .wdata_i (route_wdata),
    .raddr_i (route_raddr),
    .rdata_o (route_rdata)
  );

  spr_ctrl #(.NODES(NODES), .COST_BITS(COST_BITS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .link_cost_i   (link_cost_i),
    .link_we_o     (link_we),
    .link_waddr_o  (link_waddr),
    .link_wdata_o  (link_wdata),
    .link_raddr_o  (link_raddr),
    .link_rdata_i  (link_rdata),
    .route_we_o    (route_we),
    .route_waddr_o (route_waddr),
    .route_wdata_o (route_wdata),
    .route_raddr_o (route_raddr),
    .route_rdata_i (route_rdata),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_free_i    (res_free)
  );

  spr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res),
    .out_stall_i (out_stall_i)
  );

  assign path_node_o = out_res.node;
  assign path_cost_o = out_res.cost;
  assign reachable_o = out_res.reach;
  assign last_o      = out_res.last;

endmodule

// ----- hdl/spr_checker.sv -----
module spr_checker import spr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [1:0]           func_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [NODE_W-1:0]    path_node_o,
  input logic [DIST_W-1:0]    path_cost_o,
  input logic                 reachable_o,
  input logic                 last_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(path_node_o) &&
      $stable(path_cost_o) && $stable(reachable_o) && $stable(last_o))
    else $error("stalled result changed");

  // any real operation keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
      (func_i == FUNC_WRITE || func_i == FUNC_RECOMP || func_i == FUNC_QUERY)
      |=> in_stall_o)
    else $error("new item taken right after an operation");

  // an unreachable answer is a single item with zero cost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> last_o && path_cost_o == '0)
    else $error("malformed unreachable result");

  // while a path is still being emitted no new item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("item accepted in the middle of a path");

endmodule

bind shortest_path_routing_table_top spr_checker u_spr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .path_node_o (path_node_o),
  .path_cost_o (path_cost_o),
  .reachable_o (reachable_o),
  .last_o      (last_o)
);

// ----- bench/shortest_path_routing_table_top_test.sv -----
module shortest_path_routing_table_top_test import spr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ROUTERS = 1 << NODE_W;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // mirror of the routing tables, expected path hops kept in arrival order
  class route_board;
    logic [COST_IN_W-1:0] link_tab [N_ROUTERS][N_ROUTERS];
    logic [DIST_W-1:0]    dist_tab [N_ROUTERS][N_ROUTERS];
    logic [NODE_W-1:0]    hop_tab  [N_ROUTERS][N_ROUTERS];
    spr_res_t             pending_hops[$];
    int                   mismatches;

    function new();
      for (int i = 0; i < N_ROUTERS; i++) begin
        for (int j = 0; j < N_ROUTERS; j++) begin
          link_tab[i][j] = '0;
          dist_tab[i][j] = (i == j) ? '0 : DIST_INF;
          hop_tab[i][j]  = (i == j) ? NODE_W'(i) : '0;
        end
      end
      mismatches = 0;
    endfunction

    function void add_hop(spr_res_t h);
      pending_hops = {pending_hops, h};
    endfunction

    function void note_request(logic [1:0] func, logic [NODE_W-1:0] a,
                               logic [NODE_W-1:0] b, logic [COST_IN_W-1:0] cost);
      logic [DIST_W-1:0] scratch [N_ROUTERS][N_ROUTERS];
      logic [DIST_W:0]   sum;
      logic [DIST_W-1:0] best;
      logic [NODE_W-1:0] hop;
      logic [NODE_W-1:0] cur;
      logic [NODE_W-1:0] nh;
      logic [DIST_W:0]   acc;
      bit                fin;
      case (func)
        FUNC_WRITE: begin
          if (a != b) begin
            link_tab[a][b] = cost;
            link_tab[b][a] = cost;
          end
        end
        FUNC_RECOMP: begin
          for (int i = 0; i < N_ROUTERS; i++) begin
            for (int j = 0; j < N_ROUTERS; j++) begin
              if (i == j) begin
                dist_tab[i][j] = '0;
                hop_tab[i][j]  = NODE_W'(i);
              end else if (link_tab[i][j] != 0) begin
                dist_tab[i][j] = DIST_W'(link_tab[i][j]);
                hop_tab[i][j]  = NODE_W'(j);
              end else begin
                dist_tab[i][j] = DIST_INF;
                hop_tab[i][j]  = '0;
              end
            end
          end
          // synchronous rounds: every row reads the previous round's table
          repeat (N_ROUTERS - 1) begin
            scratch = dist_tab;
            for (int i = 0; i < N_ROUTERS; i++) begin
              for (int j = 0; j < N_ROUTERS; j++) begin
                if (i != j) begin
                  best = DIST_INF;
                  hop  = '0;
                  for (int k = 0; k < N_ROUTERS; k++) begin
                    if (k != i && link_tab[i][k] != 0 && scratch[k][j] != DIST_INF) begin
                      sum = (DIST_W+1)'(link_tab[i][k]) + (DIST_W+1)'(scratch[k][j]);
                      if (sum > {1'b0, DIST_SAT}) sum = {1'b0, DIST_SAT};
                      // strict compare keeps the lowest-index neighbour on ties
                      if (sum[DIST_W-1:0] < best) begin
                        best = sum[DIST_W-1:0];
                        hop  = NODE_W'(k);
                      end
                    end
                  end
                  dist_tab[i][j] = best;
                  hop_tab[i][j]  = hop;
                end
              end
            end
          end
        end
        FUNC_QUERY: begin
          if (dist_tab[a][b] == DIST_INF) begin
            add_hop('{node: b, cost: '0, reach: 1'b0, last: 1'b1});
          end else begin
            cur = a;
            acc = '0;
            // walk follows the hop table even if links changed since the recompute
            for (int n = 0; n < N_ROUTERS; n++) begin
              fin = (cur == b) || (n == N_ROUTERS - 1);
              add_hop('{node: cur, cost: acc[DIST_W-1:0], reach: 1'b1, last: fin});
              if (fin) break;
              nh  = hop_tab[cur][b];
              acc = acc + (DIST_W+1)'(link_tab[cur][nh]);
              if (acc > {1'b0, DIST_INF}) acc = {1'b0, DIST_INF};
              cur = nh;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_hop(spr_res_t got);
      spr_res_t want;
      if (pending_hops.size() == 0) begin
        $display("%0t: result with no query pending: node %0d cost %0d reach %0b last %0b",
                 $time, got.node, got.cost, got.reach, got.last);
        mismatches++;
        return;
      end
      want = pending_hops.pop_front();
      if (got.node != want.node) begin
        $display("%0t: path_node expected %0d actual %0d", $time, want.node, got.node);
        mismatches++;
      end
      if (got.cost != want.cost) begin
        $display("%0t: path_cost expected %0d actual %0d", $time, want.cost, got.cost);
        mismatches++;
      end
      if (got.reach != want.reach) begin
        $display("%0t: reachable expected %0b actual %0b", $time, want.reach, got.reach);
        mismatches++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           func_i      = '0;
  logic [NODE_W-1:0]    node_a_i    = '0;
  logic [NODE_W-1:0]    node_b_i    = '0;
  logic [COST_IN_W-1:0] link_cost_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [NODE_W-1:0]    path_node_o;
  logic [DIST_W-1:0]    path_cost_o;
  logic                 reachable_o;
  logic                 last_o;

  route_board board = new();
  int         burst_left = 0;
  bit         hold_request = 1'b0;

  shortest_path_routing_table_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .link_cost_i (link_cost_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .path_node_o (path_node_o),
    .path_cost_o (path_cost_o),
    .reachable_o (reachable_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  // sender bursts: back-to-back items, then a random gap
  task automatic send_item(input logic [1:0] func, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [COST_IN_W-1:0] cost);
    in_valid_i  <= 1'b1;
    func_i      <= func;
    node_a_i    <= a;
    node_b_i    <= b;
    link_cost_i <= cost;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(func, a, b, cost);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  function automatic logic [COST_IN_W-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return COST_IN_W'($urandom);
      default: return COST_IN_W'($urandom_range(1, 20));
    endcase
  endfunction

  // anything but a recompute, the unused function code included
  task automatic send_noise();
    logic [1:0] func;
    case ($urandom_range(0, 2))
      0: func = FUNC_WRITE;
      1: func = FUNC_QUERY;
      default: func = FUNC_UNUSED;
    endcase
    send_item(func, NODE_W'($urandom), NODE_W'($urandom), COST_IN_W'($urandom));
  endtask

  task automatic send_random_link();
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    a = NODE_W'($urandom);
    b = ($urandom_range(0, 11) == 0) ? a : NODE_W'($urandom);
    send_item(FUNC_WRITE, a, b, pick_cost());
  endtask

  initial begin : stimulus
    int                order [N_ROUTERS];
    int                kind;
    int                swap_at;
    int                tmp;
    logic [NODE_W-1:0] src;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tables, self route, extremes, stale walks
    send_item(FUNC_QUERY, 4'd0, 4'd1, '0);
    send_item(FUNC_QUERY, 4'd6, 4'd6, '0);
    send_item(FUNC_WRITE, 4'd0, 4'd1, 16'd1);
    send_item(FUNC_WRITE, 4'd1, 4'd2, 16'hFFFF);
    send_item(FUNC_WRITE, 4'd2, 4'd3, 16'd5);
    send_item(FUNC_WRITE, 4'd0, 4'd3, 16'hFFFF);
    send_item(FUNC_WRITE, 4'd15, 4'd14, 16'hFFFF);
    send_item(FUNC_WRITE, 4'd14, 4'd0, 16'd3);
    send_item(FUNC_WRITE, 4'd4, 4'd4, 16'd7);
    send_item(FUNC_UNUSED, 4'd15, 4'd15, 16'hFFFF);
    send_item(FUNC_RECOMP, 4'd0, 4'd0, '0);
    send_item(FUNC_QUERY, 4'd0, 4'd3, '0);
    send_item(FUNC_QUERY, 4'd3, 4'd15, '0);
    send_item(FUNC_QUERY, 4'd15, 4'd2, '0);
    send_item(FUNC_QUERY, 4'd9, 4'd10, '0);
    send_item(FUNC_QUERY, 4'd4, 4'd4, '0);
    send_item(FUNC_WRITE, 4'd0, 4'd3, 16'd0);
    send_item(FUNC_QUERY, 4'd0, 4'd3, '0);
    send_item(FUNC_WRITE, 4'd14, 4'd0, 16'd9);
    send_item(FUNC_QUERY, 4'd15, 4'd1, '0);
    send_item(FUNC_RECOMP, 4'd15, 4'd15, 16'hFFFF);
    send_item(FUNC_QUERY, 4'd0, 4'd3, '0);
    send_item(FUNC_QUERY, 4'd15, 4'd15, '0);
    send_item(FUNC_QUERY, 4'd0, 4'd15, '0);

    for (int phase = 0; phase < 6; phase++) begin
      kind = (phase == 0) ? 0 : $urandom_range(0, 2);
      for (int i = 0; i < N_ROUTERS; i++) order[i] = i;
      for (int i = N_ROUTERS - 1; i > 0; i--) begin
        swap_at = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[swap_at];
        order[swap_at] = tmp;
      end
      if (kind == 0) begin
        // line through all routers in random order gives the longest paths
        for (int i = 0; i + 1 < N_ROUTERS; i++) begin
          send_item(FUNC_WRITE, NODE_W'(order[i]), NODE_W'(order[i+1]),
                    COST_IN_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 40)));
          if ($urandom_range(0, 7) == 0) send_noise();
        end
      end else begin
        repeat ((kind == 1) ? 12 : 28) send_random_link();
      end
      repeat (2) send_noise();
      send_item(FUNC_RECOMP, NODE_W'($urandom), NODE_W'($urandom), COST_IN_W'($urandom));
      if (kind == 0) begin
        send_item(FUNC_QUERY, NODE_W'(order[0]), NODE_W'(order[N_ROUTERS-1]), '0);
        send_item(FUNC_QUERY, NODE_W'(order[N_ROUTERS-1]), NODE_W'(order[0]), '0);
      end
      // results are on their way now, so the hold-off backs the block up
      if (phase == 0) hold_request = 1'b1;
      repeat (38) begin
        if ($urandom_range(0, 9) == 0) send_random_link();
        if ($urandom_range(0, 14) == 0) send_noise();
        src = NODE_W'($urandom);
        send_item(FUNC_QUERY, src, ($urandom_range(0, 7) == 0) ? src : NODE_W'($urandom),
                  COST_IN_W'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    while (board.pending_hops.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("shortest_path_routing_table_top_test: done, clean");
    end else begin
      $display("shortest_path_routing_table_top_test: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    int left;
    bit hold_done;
    mode = 0;
    left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        // long hold-off so the block backs up and stalls its input
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(5, 120);
        end
        left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_hop('{node: path_node_o, cost: path_cost_o, reach: reachable_o,
                        last: last_o});
    end
  end

  initial begin : watchdog
    #40ms;
    $display("shortest_path_routing_table_top_test: done, errors");
    $finish;
  end

endmodule
